// ===== rtl/pfsm_pkg.sv =====
package pfsm_pkg;

  // Field widths of the request and reply channels.
  localparam int INDEX_W = 12;
  localparam int COUNT_W = 13;
  localparam int BYTE_W  = 8;

  // Table entries packed into one memory word.
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int WORD_W = LANES * BYTE_W;

  // Default table capacity; only the pages the index can reach are stored.
  localparam int PAGES_DEFAULT = 4096;
  localparam int INDEX_REACH   = 2 ** INDEX_W;

  // Free-space byte that stands for unknown or unusable.
  localparam logic [BYTE_W-1:0] UNKNOWN_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_FIND  = 2'd2,
    REQ_CLEAN = 2'd3
  } req_type_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic start;
    logic scan_next;
    logic load_out;
  } pfsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic in_cap;
    logic scan_done;
    logic out_free;
  } pfsm_status_t;

endpackage

// ===== rtl/page_free_space_map_unit.sv =====
// Channel   Handshake             Payload
// request   in_valid / in_ready   req_type, page_index, percent_value, min_percent
// reply     out_valid / out_ready read_percent, found_page, found, page_count,
//                                 dirty, index_error
//
// One request is worked on at a time. Get, set, clean and an out-of-range
// index go from acceptance through the get, set or reply state into the reply
// register, waiting in that state while the register is full. A find scans
// one memory word at a time (8 pages to a word); the table memory has a single read port.
// After reset the table memory is filled with 255, one word a cycle, while
// in_ready stays low.
// A reply that waits in the output register does not block acceptance of the
// next request; the following reply then waits until the register is freed.
module page_free_space_map_unit
  import pfsm_pkg::*;
#(
  parameter int PAGES = PAGES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [INDEX_W-1:0] page_index,
  input  logic [BYTE_W-1:0]  percent_value,
  input  logic [BYTE_W-1:0]  min_percent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  read_percent,
  output logic [INDEX_W-1:0] found_page,
  output logic               found,
  output logic [COUNT_W-1:0] page_count,
  output logic               dirty,
  output logic               index_error
);

  pfsm_cmd_t    cmd;
  pfsm_status_t status;

  // The controller sequences the clearing pass, the request steps and the
  // loading of the reply register.
  pfsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // The datapath holds the table memory, the page count, the dirty mark, the
  // captured request, the word-wide scan logic and the reply register.
  pfsm_dp #(
    .PAGES (PAGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req_type),
    .page_index    (page_index),
    .percent_value (percent_value),
    .min_percent   (min_percent),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_percent  (read_percent),
    .found_page    (found_page),
    .found         (found),
    .page_count    (page_count),
    .dirty         (dirty),
    .index_error   (index_error)
  );

endmodule

// ===== rtl/pfsm_ctrl.sv =====
module pfsm_ctrl
  import pfsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   req_type,
  input  pfsm_status_t status,
  output logic         in_ready,
  output pfsm_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_GET   = 6'b000100,
    ST_SET   = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_REPLY = 6'b100000
  } state_t;

  state_t    state;
  state_t    state_next;
  req_type_t rt;

  assign rt = req_type_t'(req_type);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          priority if (!status.in_cap || rt == REQ_CLEAN) begin
            state_next = ST_REPLY;
          end else if (rt == REQ_GET) begin
            state_next = ST_GET;
          end else if (rt == REQ_SET) begin
            state_next = ST_SET;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_GET, ST_SET, ST_REPLY: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pfsm_dp.sv =====
module pfsm_dp
  import pfsm_pkg::*;
#(
  parameter int PAGES = PAGES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  pfsm_cmd_t          cmd,
  output pfsm_status_t       status,
  input  logic [1:0]         req_type,
  input  logic [INDEX_W-1:0] page_index,
  input  logic [BYTE_W-1:0]  percent_value,
  input  logic [BYTE_W-1:0]  min_percent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  read_percent,
  output logic [INDEX_W-1:0] found_page,
  output logic               found,
  output logic [COUNT_W-1:0] page_count,
  output logic               dirty,
  output logic               index_error
);

  localparam int DEPTH = (PAGES < INDEX_REACH) ? PAGES : INDEX_REACH;
  localparam int WORDS = (DEPTH + LANES - 1) / LANES;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);
  localparam logic [WAW-1:0]     LAST_WORD = WAW'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];

  // Captured request.
  req_type_t          rq_type;
  logic [INDEX_W-1:0] rq_index;
  logic [BYTE_W-1:0]  rq_value;
  logic [BYTE_W-1:0]  rq_min;
  logic               rq_err;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               dirty_mark;
  logic               dirty_next;
  logic [WAW-1:0]     clr_addr;
  logic [WAW-1:0]     eval_word;
  logic [WORD_W-1:0]  rdata;

  logic [INDEX_W-LANE_W-1:0] in_word;
  logic [INDEX_W-LANE_W-1:0] rq_word;
  logic [WAW-1:0]            rd_addr;
  logic                      rd_en;
  logic [WAW-1:0]            wr_addr;
  logic [WORD_W-1:0]         wr_data;
  logic                      we;
  logic                      in_cap;

  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] lane_page [LANES];
  logic [BYTE_W-1:0]  lane_byte [LANES];
  logic [LANES-1:0]   lane_ok;
  logic               hit;
  logic [LANE_W-1:0]  hit_lane;
  logic               scan_last;

  logic [LANE_W-1:0]  lane_sel;
  logic [BYTE_W-1:0]  old_byte;
  logic [WORD_W-1:0]  set_word;
  logic               grow;
  logic               changed;
  logic               commit;
  logic               out_free;

  assign in_cap  = {1'b0, page_index} < DEPTH_C;
  assign in_word = page_index[INDEX_W-1:LANE_W];
  assign rq_word = rq_index[INDEX_W-1:LANE_W];
  assign rd_en   = (cmd.start && in_cap) || cmd.scan_next;
  assign rd_addr = cmd.start ? in_word[WAW-1:0] : WAW'(eval_word + WAW'(1));

  // Scan of one word: every lane checked at once, the lowest hit wins.
  assign base = COUNT_W'({eval_word, LANE_W'(0)});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_page[l] = base | COUNT_W'(l);
      lane_byte[l] = rdata[l*BYTE_W +: BYTE_W];
      lane_ok[l]   = (lane_page[l] >= {1'b0, rq_index}) && (lane_page[l] < count) &&
                     (lane_byte[l] >= rq_min) && (lane_byte[l] != UNKNOWN_BYTE);
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_ok[l]) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
  end

  assign scan_last = (COUNT_W'(base + COUNT_W'(LANES)) >= count) || (eval_word == LAST_WORD);

  // Read-modify-write of the addressed byte for set, plain read for get.
  assign lane_sel = rq_index[LANE_W-1:0];
  assign old_byte = rdata[lane_sel*BYTE_W +: BYTE_W];

  always_comb begin
    set_word = rdata;
    set_word[lane_sel*BYTE_W +: BYTE_W] = rq_value;
  end

  assign grow    = {1'b0, rq_index} >= count;
  assign changed = old_byte != rq_value;
  assign commit  = cmd.load_out && rq_type == REQ_SET && !rq_err;

  always_comb begin
    count_next = count;
    dirty_next = dirty_mark;
    if (commit) begin
      if (grow) begin
        count_next = COUNT_W'({1'b0, rq_index} + COUNT_W'(1));
      end
      dirty_next = dirty_mark | grow | changed;
    end else if (cmd.load_out && rq_type == REQ_CLEAN) begin
      dirty_next = 1'b0;
    end
  end

  assign we      = cmd.clear_we || commit;
  assign wr_addr = cmd.clear_we ? clr_addr : rq_word[WAW-1:0];
  assign wr_data = cmd.clear_we ? {WORD_W{1'b1}} : set_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata     <= mem[rd_addr];
      eval_word <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rq_type  <= req_type_t'(req_type);
      rq_index <= page_index;
      rq_value <= percent_value;
      rq_min   <= min_percent;
      rq_err   <= !in_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      count      <= '0;
      dirty_mark <= 1'b0;
    end else begin
      if (cmd.clear_we) begin
        clr_addr <= WAW'(clr_addr + WAW'(1));
      end
      count      <= count_next;
      dirty_mark <= dirty_next;
    end
  end

  // Output register.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_percent <= '0;
      found_page   <= '0;
      found        <= 1'b0;
      if (rq_type == REQ_GET) begin
        read_percent <= (!rq_err && {1'b0, rq_index} < count) ? old_byte : UNKNOWN_BYTE;
      end
      if (rq_type == REQ_FIND && !rq_err && hit) begin
        found_page <= INDEX_W'(base | COUNT_W'(hit_lane));
        found      <= 1'b1;
      end
      page_count  <= count_next;
      dirty       <= dirty_next;
      index_error <= rq_err && rq_type != REQ_CLEAN;
    end
  end

  assign status.clear_last = clr_addr == LAST_WORD;
  assign status.in_cap     = in_cap;
  assign status.scan_done  = hit || scan_last;
  assign status.out_free   = out_free;

endmodule

// ===== rtl/pfsm_check.sv =====
module pfsm_check
  import pfsm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         req_type,
  input logic [INDEX_W-1:0] page_index,
  input logic [BYTE_W-1:0]  percent_value,
  input logic [BYTE_W-1:0]  min_percent,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  read_percent,
  input logic [INDEX_W-1:0] found_page,
  input logic               found,
  input logic [COUNT_W-1:0] page_count,
  input logic               dirty,
  input logic               index_error
);

  // The table is still being filled right after reset.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken right after reset");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_reply_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found_page) && $stable(page_count)
      && $stable(read_percent) && $stable(dirty))
    else $error("stalled reply changed");

  a_no_page_without_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> found_page == '0)
    else $error("page reported without a hit");

  a_error_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> !found)
    else $error("hit reported on an index error");

endmodule

bind page_free_space_map_unit pfsm_check u_check (.*);
